[rtl/dctd_pkg.sv]
// ----------------------------------------------------------------------------
// dctd_pkg
// Shared widths, types and constants of the trial-division divisor counter.
// ----------------------------------------------------------------------------
package dctd_pkg;

  localparam int Width     = 32;
  localparam int DivW      = Width / 2 + 1;
  localparam int ExpW      = $clog2(Width + 1);
  localparam int CntW      = $clog2(Width + 1);
  localparam int CountW    = 11;
  localparam int CountMax  = 2047;
  localparam int InDataW   = ((Width + 7) / 8) * 8;
  localparam int OutDataW  = ((CountW + 7) / 8) * 8;
  localparam int ProdW     = CountW + ExpW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[rtl/divisor_count_trial_division.sv]
// ----------------------------------------------------------------------------
// divisor_count_trial_division
// Counts the positive divisors of an unsigned number by trial division.
//
// One number enters on the s_axis channel, one count leaves on m_axis.
// Candidates d = 2, 3, ... are tried while d * d does not exceed the value;
// every step is one pass of a shared bit-serial divider that yields both
// the quotient (used for the loop bound) and the remainder.
// Each candidate and each prime factor costs one division, so the latency
// grows with (number of candidates + number of prime factors) and is
// longest for a large 32-bit prime; the divider sets it.
// Input ready is high only while no number is in work; the next number
// may be taken while the previous count waits in the output register.
// When the receiver stalls, a finished count waits in its final state
// until the output register is free. Reset empties the block and drops
// any count not yet delivered. Inputs 0 and 1 give a count of 1.
// ----------------------------------------------------------------------------
module divisor_count_trial_division (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [dctd_pkg::InDataW-1:0]  s_axis_tdata_i,  // number
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [dctd_pkg::OutDataW-1:0] m_axis_tdata_o   // divisor_count
);
  import dctd_pkg::*;

  state_e            state_q, state_d;
  logic [Width-1:0]  val_q, val_d;
  logic [DivW-1:0]   div_q, div_d;
  logic [ExpW-1:0]   exp_q, exp_d;
  logic [CountW-1:0] tot_q, tot_d;
  logic              in_exp_q, in_exp_d;
  logic [CountW-1:0] out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              div_start;
  div_status_t       div_stat;
  logic [Width-1:0]  div_quo;
  logic [DivW-1:0]   div_rem;

  logic [ExpW-1:0]   factor;
  logic [ProdW-1:0]  prod;
  logic [CountW-1:0] prod_sat;
  logic              quo_lt;
  logic              rem_zero;
  logic              load_out;

  dctd_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (val_q),
    .divisor_i   (div_q),
    .status_o    (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // saturating running product
  always_comb begin
    factor   = (state_q == ST_FINISH) ? ExpW'(2) : exp_q + 1'b1;
    prod     = ProdW'(tot_q) * ProdW'(factor);
    prod_sat = (prod > ProdW'(CountMax)) ? CountW'(CountMax) : prod[CountW-1:0];
    quo_lt   = (div_quo < Width'(div_q));
    rem_zero = (div_rem == '0);
  end

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    div_d       = div_q;
    exp_d       = exp_q;
    tot_d       = tot_q;
    in_exp_d    = in_exp_q;
    out_d       = out_q;
    div_start   = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          val_d    = s_axis_tdata_i[Width-1:0];
          div_d    = DivW'(2);
          tot_d    = CountW'(1);
          exp_d    = '0;
          in_exp_d = 1'b0;
          state_d  = ST_START;
        end
      end
      ST_START: begin
        div_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          if (in_exp_q) begin
            if (rem_zero) begin
              val_d   = div_quo;
              exp_d   = exp_q + 1'b1;
              state_d = ST_START;
            end else begin
              tot_d    = prod_sat;
              in_exp_d = 1'b0;
              div_d    = div_q + 1'b1;
              state_d  = ST_START;
            end
          end else if (quo_lt) begin
            state_d = ST_FINISH;
          end else if (rem_zero) begin
            val_d    = div_quo;
            exp_d    = ExpW'(1);
            in_exp_d = 1'b1;
            state_d  = ST_START;
          end else begin
            div_d   = div_q + 1'b1;
            state_d = ST_START;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          out_d    = (val_q > Width'(1)) ? prod_sat : tot_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = load_out || (out_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      in_exp_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      in_exp_q    <= in_exp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    div_q <= div_d;
    exp_q <= exp_d;
    tot_q <= tot_d;
    out_q <= out_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_q);

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_exp_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_exp_q && state_q != ST_IDLE) |-> (exp_q != '0))
    else $error("exponent loop with zero exponent");

  a_divisor_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_START || state_q == ST_WAIT) |-> (div_q >= DivW'(2)))
    else $error("trial divisor below two");

  a_total_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (tot_q != '0))
    else $error("running total is zero");

endmodule

[rtl/dctd_divider.sv]
// ----------------------------------------------------------------------------
// dctd_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by all steps.
// ----------------------------------------------------------------------------
module dctd_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dctd_pkg::Width-1:0] dividend_i,
  input  logic [dctd_pkg::DivW-1:0]  divisor_i,
  output dctd_pkg::div_status_t      status_o,
  output logic [dctd_pkg::Width-1:0] quotient_o,
  output logic [dctd_pkg::DivW-1:0]  remainder_o
);
  import dctd_pkg::*;

  logic [Width-1:0] quo_q;
  logic [DivW-1:0]  rem_q;
  logic [DivW-1:0]  dsr_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DivW:0]    trial;
  logic [DivW:0]    diff;
  logic             qbit;
  logic [DivW-1:0]  rem_next;

  always_comb begin
    trial    = {rem_q, quo_q[Width-1]};
    diff     = trial - {1'b0, dsr_q};
    qbit     = (trial >= {1'b0, dsr_q});
    rem_next = qbit ? diff[DivW-1:0] : trial[DivW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[Width-2:0], qbit};
      rem_q <= rem_next;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule
